@@ rtl/ccfb_pkg.sv @@
// shared types, constants and functions of the command frame builder
// no dependencies; used by every module under rtl
`default_nettype none

package ccfb_pkg;

    typedef enum logic [1:0] {
        OP_SET_PRESS  = 2'd0,
        OP_READ_PRESS = 2'd1,
        OP_SET_PID    = 2'd2,
        OP_READ_PID   = 2'd3
    } t_op;

    // one command frame ready to serialize
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] regn;
        logic [7:0] sub;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       last;   // final frame of its request
    } t_frame;

    // front status seen by the top level
    typedef struct packed {
        logic busy;
        logic push;
        logic fin;
    } t_front_stat;

    localparam logic [7:0]  SYNC_BYTE       = 8'h5E;
    localparam logic [7:0]  REG_PRESS       = 8'h19;
    localparam logic [7:0]  SUB_PRESS_SET   = 8'h80;
    localparam logic [7:0]  SUB_PRESS_READ  = 8'h00;
    localparam logic [7:0]  ADDR_PRESS_BASE = 8'h0A;
    localparam logic [7:0]  ADDR_PRESS_LAST = 8'h0C;
    localparam logic [7:0]  CHAN_FIRST      = 8'd1;
    localparam logic [7:0]  CHAN_LAST       = 8'd3;
    localparam logic [2:0]  PID_ALL_IDX     = 3'd5;
    localparam logic [2:0]  PID_LAST_IDX    = 3'd4;
    localparam logic [2:0]  PRESS_LAST_CNT  = 3'd2;
    localparam logic [15:0] CHK_INIT        = 16'hFFFF;
    localparam logic [15:0] CHK_POLY        = 16'h1021;
    localparam logic [31:0] PID_BODY_RESET  = 32'h0000_8116;
    localparam int          QUEUE_DEPTH     = 4;
    localparam int          QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [2:0]  POS_SUB = 3'd3;
    localparam logic [2:0]  POS_HI  = 3'd5;
    localparam logic [2:0]  POS_END = 3'd7;

    function automatic logic [7:0] pid_reg(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd3:    r = 8'h17;
            3'd4:    r = 8'h18;
            default: r = 8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pid_read_sub(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h01;
            3'd1:    r = 8'h02;
            3'd2:    r = 8'h03;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pid_set_sub(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h81;
            3'd1:    r = 8'h82;
            3'd2:    r = 8'h83;
            default: r = 8'h80;
        endcase
        return r;
    endfunction

    // reflected check update over one byte, lsb first
    function automatic logic [15:0] check_byte(input logic [15:0] c_in,
                                               input logic [7:0]  d);
        logic [15:0] c;
        c = c_in;
        for (int b = 0; b < 8; b++) begin
            if (c[0] ^ d[b]) begin
                c = (c >> 1) ^ CHK_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ccfb_front.sv @@
// request front end: takes requests, keeps address and pid body state,
// expands each request into frame descriptors; uses ccfb_pkg
`default_nettype none

module ccfb_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire ccfb_pkg::t_op        i_op,
    input  wire logic [7:0]           i_addr,
    input  wire logic [2:0]           i_idx,
    input  wire logic [15:0]          i_value,
    input  wire logic                 i_full,
    output ccfb_pkg::t_frame          o_frame,
    output ccfb_pkg::t_front_stat     o_stat
);

    logic              r_busy, n_busy;
    logic [2:0]        r_cnt, n_cnt;
    logic [2:0]        r_last_cnt, n_last_cnt;
    ccfb_pkg::t_op     r_op, n_op;
    logic [7:0]        r_addr, n_addr;
    logic [2:0]        r_idx, n_idx;
    logic [15:0]       r_val, n_val;
    logic [7:0]        r_press, n_press;
    logic [31:0]       r_body, n_body;

    logic       push, fin, accept, has_frames;
    logic [2:0] last_cnt;
    logic [2:0] k;

    assign push    = r_busy && !i_full;
    assign fin     = (r_cnt == r_last_cnt);
    assign o_ready = !r_busy || (push && fin);
    assign accept  = i_valid && o_ready;

    // frame count of the incoming request
    always_comb begin
        has_frames = 1'b1;
        last_cnt   = 3'd0;
        unique case (i_op)
            ccfb_pkg::OP_SET_PRESS,
            ccfb_pkg::OP_SET_PID:    last_cnt = 3'd0;
            ccfb_pkg::OP_READ_PRESS: last_cnt = ccfb_pkg::PRESS_LAST_CNT;
            ccfb_pkg::OP_READ_PID: begin
                if (i_idx == ccfb_pkg::PID_ALL_IDX) begin
                    last_cnt = ccfb_pkg::PID_LAST_IDX;
                end else if (i_idx > ccfb_pkg::PID_ALL_IDX) begin
                    has_frames = 1'b0;
                end
            end
            default: has_frames = 1'b0;
        endcase
    end

    always_comb begin
        n_busy     = r_busy;
        n_cnt      = r_cnt;
        n_last_cnt = r_last_cnt;
        n_op       = r_op;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_val      = r_val;
        n_press    = r_press;
        n_body     = r_body;
        if (push) begin
            n_cnt = r_cnt + 3'd1;
            if (fin) begin
                n_busy = 1'b0;
            end
        end
        if (accept) begin
            n_busy     = has_frames;
            n_cnt      = 3'd0;
            n_last_cnt = last_cnt;
            n_op       = i_op;
            n_addr     = i_addr;
            n_idx      = i_idx;
            n_val      = i_value;
            if (i_op == ccfb_pkg::OP_SET_PRESS && i_addr >= ccfb_pkg::CHAN_FIRST
                    && i_addr <= ccfb_pkg::CHAN_LAST) begin
                n_press = ccfb_pkg::ADDR_PRESS_BASE + (i_addr - ccfb_pkg::CHAN_FIRST);
            end
            // out-of-range index keeps the stored body
            if (i_op == ccfb_pkg::OP_SET_PID && i_idx <= ccfb_pkg::PID_LAST_IDX) begin
                n_body = {i_value[15:8], i_value[7:0],
                          ccfb_pkg::pid_set_sub(i_idx), ccfb_pkg::pid_reg(i_idx)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_press <= 8'd0;
            r_body  <= ccfb_pkg::PID_BODY_RESET;
        end else begin
            r_busy  <= n_busy;
            r_press <= n_press;
            r_body  <= n_body;
        end
        r_cnt      <= n_cnt;
        r_last_cnt <= n_last_cnt;
        r_op       <= n_op;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_val      <= n_val;
    end

    // descriptor of the frame at r_cnt
    always_comb begin
        k       = (r_idx == ccfb_pkg::PID_ALL_IDX) ? r_cnt : r_idx;
        o_frame = '0;
        o_frame.last = fin;
        unique case (r_op)
            ccfb_pkg::OP_SET_PRESS: begin
                o_frame.addr = r_press;
                o_frame.regn = ccfb_pkg::REG_PRESS;
                o_frame.sub  = ccfb_pkg::SUB_PRESS_SET;
                o_frame.lo   = r_val[7:0];
                o_frame.hi   = r_val[15:8];
            end
            ccfb_pkg::OP_READ_PRESS: begin
                o_frame.addr = ccfb_pkg::ADDR_PRESS_BASE + {5'd0, r_cnt};
                o_frame.regn = ccfb_pkg::REG_PRESS;
                o_frame.sub  = ccfb_pkg::SUB_PRESS_READ;
            end
            ccfb_pkg::OP_SET_PID: begin
                o_frame.addr = r_addr;
                o_frame.regn = r_body[7:0];
                o_frame.sub  = r_body[15:8];
                o_frame.lo   = r_body[23:16];
                o_frame.hi   = r_body[31:24];
            end
            ccfb_pkg::OP_READ_PID: begin
                o_frame.addr = r_addr;
                o_frame.regn = ccfb_pkg::pid_reg(k);
                o_frame.sub  = ccfb_pkg::pid_read_sub(k);
            end
            default: o_frame.addr = r_addr;
        endcase
    end

    assign o_stat.busy = r_busy;
    assign o_stat.push = push;
    assign o_stat.fin  = fin;

endmodule

`default_nettype wire

@@ rtl/ccfb_queue.sv @@
// short descriptor queue between front and back
// register array with read and write pointers; uses ccfb_pkg
`default_nettype none

module ccfb_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ccfb_pkg::t_frame  i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output ccfb_pkg::t_frame       o_data
);

    localparam int AW = ccfb_pkg::QUEUE_AW;

    ccfb_pkg::t_frame r_mem [ccfb_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(ccfb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ccfb_back.sv @@
// frame serializer: one byte per cycle into a registered output while it is not
// stalled, check word folded in byte by byte; uses ccfb_pkg
`default_nettype none

module ccfb_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire ccfb_pkg::t_frame  i_frame,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  wire logic              i_tready,
    output logic [7:0]             o_tdata,
    output logic                   o_tlast
);

    logic             r_active, n_active;
    ccfb_pkg::t_frame r_frame, n_frame;
    logic [2:0]       r_pos, n_pos;
    logic [15:0]      r_chk, n_chk;
    logic             r_tvalid, n_tvalid;
    logic [7:0]       r_tdata, n_tdata;
    logic             r_tlast, n_tlast;

    logic        adv;
    logic [7:0]  cur_byte;
    logic [15:0] chk_out;

    assign adv     = !r_tvalid || i_tready;
    assign chk_out = r_chk + 16'd1;
    assign o_pop   = i_valid && (!r_active || (adv && r_pos == ccfb_pkg::POS_END));

    always_comb begin
        unique case (r_pos)
            3'd0:    cur_byte = ccfb_pkg::SYNC_BYTE;
            3'd1:    cur_byte = r_frame.addr;
            3'd2:    cur_byte = r_frame.regn;
            3'd3:    cur_byte = r_frame.sub;
            3'd4:    cur_byte = r_frame.lo;
            3'd5:    cur_byte = r_frame.hi;
            3'd6:    cur_byte = chk_out[7:0];
            default: cur_byte = chk_out[15:8];
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_frame  = r_frame;
        n_pos    = r_pos;
        n_chk    = r_chk;
        n_tvalid = r_tvalid;
        n_tdata  = r_tdata;
        n_tlast  = r_tlast;
        if (adv) begin
            n_tvalid = r_active;
            n_tdata  = cur_byte;
            n_tlast  = r_frame.last && (r_pos == ccfb_pkg::POS_END);
            if (r_active) begin
                n_pos = r_pos + 3'd1;
                if (r_pos >= ccfb_pkg::POS_SUB && r_pos <= ccfb_pkg::POS_HI) begin
                    n_chk = ccfb_pkg::check_byte(r_chk, cur_byte);
                end
                if (r_pos == ccfb_pkg::POS_END) begin
                    n_active = 1'b0;
                end
            end
        end
        if (o_pop) begin
            n_active = 1'b1;
            n_frame  = i_frame;
            n_pos    = 3'd0;
            n_chk    = ccfb_pkg::CHK_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_tvalid <= n_tvalid;
        end
        r_frame <= n_frame;
        r_pos   <= n_pos;
        r_chk   <= n_chk;
        r_tdata <= n_tdata;
        r_tlast <= n_tlast;
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

endmodule

`default_nettype wire

@@ rtl/controller_command_frame_builder_core.sv @@
// top level of the pressure controller command frame builder
// depends on ccfb_pkg, ccfb_front, ccfb_queue, ccfb_back
//
// usage:
//   s_axis carries one request per item: tuser is the operation (set pressure,
//   read pressures, set pid parameter, read pid parameter); tdata holds the
//   address or channel, the pid parameter index and the 16-bit value.
//   m_axis carries the command frames one byte per item, 8 bytes per frame;
//   tlast marks the final byte caused by a request. a read of pid index 6 or 7
//   gives no bytes at all.
// timing:
//   the first byte passes the front, queue, serializer and output registers.
//   the back end sends one byte per cycle while m_axis_tready is high, with
//   no gap between frames, so a request is 1, 3 or 5 frames of 8 bytes; that
//   byte rate is the limit. the front queues one frame per cycle into a 4-deep
//   descriptor queue unless it is full, takes the next request in the cycle its
//   last frame is queued, so short requests go back to back while bytes drain.
// reset: synchronous, active low; clears the queue and the output, sets the
//   pressure address to zero and the stored pid body to 0x16 0x81 0x00 0x00.
// stall: when m_axis_tready is low the output byte holds, the serializer
//   waits, the queue fills and s_axis_tready drops once it is full.
`default_nettype none

module controller_command_frame_builder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // address[7:0], parameter_index[10:8],
                                             // value[26:11], zero[31:27]
    input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // frame_byte[7:0]
    output logic             m_axis_tlast    // last
);

    ccfb_pkg::t_frame      front_frame;
    ccfb_pkg::t_frame      q_frame;
    ccfb_pkg::t_front_stat front_stat;
    logic                  q_full;
    logic                  q_valid;
    logic                  back_pop;

    // request expansion and state update
    ccfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (ccfb_pkg::t_op'(s_axis_tuser)),
        .i_addr  (s_axis_tdata[7:0]),
        .i_idx   (s_axis_tdata[10:8]),
        .i_value (s_axis_tdata[26:11]),
        .i_full  (q_full),
        .o_frame (front_frame),
        .o_stat  (front_stat)
    );

    // decouples expansion from the byte stream
    ccfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_stat.push),
        .i_data  (front_frame),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_data  (q_frame)
    );

    // byte serializer with check word
    ccfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_frame  (q_frame),
        .o_pop    (back_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    // a queued frame never lands in a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_stat.push |-> !q_full)
        else $error("frame pushed into full queue");

    // a new request while expanding only on the cycle the last frame is queued
    a_accept_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && front_stat.busy)
            |-> (front_stat.push && front_stat.fin))
        else $error("request taken while still expanding");

    // serializer only loads when a frame is waiting
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
